>>> rtl/pps_pkg.sv
// Package for the preemptive priority scheduler: beat types, codes and the
// command and status structs between controller and datapath. No dependencies.
package pps_pkg;

	localparam int MAX_JOBS_DEF  = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 4;
	localparam int OUT_T_W = 16;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_e;

	typedef enum logic [KIND_W-1:0] {
		K_IDLE     = 3'd0,
		K_RAN      = 3'd1,
		K_FINISHED = 3'd2,
		K_REFUSED  = 3'd3,
		K_LOADED   = 3'd4
	} kind_e;

	typedef struct packed {
		logic               operation;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} in_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [IDX_W-1:0]   job_index;
		logic [OUT_T_W-1:0] time_now;
		logic [OUT_T_W-1:0] turnaround;
		logic [OUT_T_W-1:0] waiting;
		logic [OUT_T_W-1:0] response;
		logic               all_done;
	} out_beat_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic scan_rd;
		logic update;
		logic finish;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic req_op;
		logic table_empty;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/pps_ctrl.sv
// Controller of the preemptive priority scheduler: sequences load, table scan,
// update and result hand-over. Depends on pps_pkg.
module pps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pps_pkg::dp_stat_t stat,
	output pps_pkg::dp_cmd_t  cmd
);
	import pps_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOAD   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_UPDATE = 7'b0010000,
		ST_FINISH = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (stat.req_op == OP_LOAD) begin
						state_nxt = ST_LOAD;
					end else if (stat.table_empty) begin
						state_nxt = ST_UPDATE;
					end else begin
						state_nxt = ST_SCAN;
					end
				end
			end
			ST_LOAD: begin
				cmd.load  = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nxt  = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> rtl/pps_dpath.sv
// Datapath of the preemptive priority scheduler: job table memory, scan
// comparator, clock and counters, and the output register. Depends on pps_pkg.
module pps_dpath #(
	parameter int MAX_JOBS  = pps_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pps_pkg::in_beat_t  req,
	input  pps_pkg::dp_cmd_t   cmd,
	output pps_pkg::dp_stat_t  stat,
	input  logic               rsp_stall,
	output logic               rsp_valid,
	output pps_pkg::out_beat_t rsp
);
	import pps_pkg::*;

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int WW = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

	typedef struct packed {
		logic [TIME_BITS-1:0] arrival;
		logic [BURST_W-1:0]   burst;
		logic [BURST_W-1:0]   remaining;
		logic [PRIO_W-1:0]    prio;
		logic [TIME_BITS-1:0] first_start;
	} rec_t;

	rec_t mem [MAX_JOBS];
	rec_t rd_q;
	rec_t rec_q;
	rec_t upd_rec;
	rec_t load_rec;
	rec_t mem_wdata;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;

	logic [IW-1:0]       rd_idx_s1;
	logic                rvalid_s1;
	logic [IW-1:0]       scan_idx_q;
	logic                found_q;
	logic [IW-1:0]       pick_q;
	logic [MAX_JOBS-1:0] done_q;
	logic [CW-1:0]       job_count_q;
	logic [CW-1:0]       fin_count_q;
	logic [TIME_BITS-1:0] clock_q;
	logic [TIME_BITS-1:0] start_q;

	logic [TIME_BITS-1:0] arr_in_q;
	logic [BURST_W-1:0]   bur_in_q;
	logic [PRIO_W-1:0]    pri_in_q;

	kind_e                kind_q;
	logic [IW-1:0]        idx_q;
	logic [TIME_BITS-1:0] tat_q;
	logic [TIME_BITS-1:0] rt_q;

	logic                 out_valid_q;
	out_beat_t            out_q;

	logic                 refuse;
	logic                 cand_ok;
	logic                 job_ends;
	logic                 finished;
	logic [WW-1:0]        wait_w;

	assign refuse = (bur_in_q == '0) || (job_count_q >= CW'(MAX_JOBS));

	assign cand_ok = rvalid_s1 && !done_q[rd_idx_s1] && (rd_q.arrival <= clock_q)
		&& (!found_q || (rd_q.prio > rec_q.prio));

	always_comb begin
		upd_rec             = rec_q;
		upd_rec.remaining   = rec_q.remaining - BURST_W'(1);
		upd_rec.first_start = (rec_q.remaining == rec_q.burst) ? start_q
			: rec_q.first_start;
	end

	always_comb begin
		load_rec.arrival     = arr_in_q;
		load_rec.burst       = bur_in_q;
		load_rec.remaining   = bur_in_q;
		load_rec.prio        = pri_in_q;
		load_rec.first_start = '0;
	end

	assign job_ends = found_q && (rec_q.remaining == BURST_W'(1));
	assign finished = found_q && (rec_q.remaining == '0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pick_q;
		mem_wdata = upd_rec;
		if (cmd.load && !refuse) begin
			mem_we    = 1'b1;
			mem_waddr = IW'(job_count_q);
			mem_wdata = load_rec;
		end else if (cmd.update && found_q) begin
			mem_we = 1'b1;
		end
	end

	// Job table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.scan_rd) begin
			rd_q <= mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1   <= 1'b0;
			scan_idx_q  <= '0;
			found_q     <= 1'b0;
			done_q      <= '0;
			job_count_q <= '0;
			fin_count_q <= '0;
			clock_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.scan_rd;
			if (cmd.accept) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_idx_q <= scan_idx_q + IW'(1);
				end
				if (cand_ok) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.load && !refuse) begin
				done_q[IW'(job_count_q)] <= 1'b0;
				job_count_q              <= job_count_q + CW'(1);
			end
			if (cmd.update) begin
				if (clock_q != TMAX) begin
					clock_q <= clock_q + TIME_BITS'(1);
				end
				if (job_ends) begin
					done_q[pick_q] <= 1'b1;
					fin_count_q    <= fin_count_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Waiting saturates at zero when a stopped clock leaves turnaround below burst.
	always_comb begin
		wait_w = '0;
		if ((kind_q == K_FINISHED) && (WW'(tat_q) >= WW'(rec_q.burst))) begin
			wait_w = WW'(tat_q) - WW'(rec_q.burst);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			arr_in_q <= TIME_BITS'(req.arrival);
			bur_in_q <= req.burst;
			pri_in_q <= req.prio;
			start_q  <= clock_q;
		end
		if (cmd.scan_rd) begin
			rd_idx_s1 <= scan_idx_q;
		end
		if (cand_ok) begin
			pick_q <= rd_idx_s1;
			rec_q  <= rd_q;
		end else if (cmd.update && found_q) begin
			rec_q <= upd_rec;
		end
		if (cmd.load) begin
			kind_q <= refuse ? K_REFUSED : K_LOADED;
			idx_q  <= refuse ? '0 : IW'(job_count_q);
			tat_q  <= '0;
			rt_q   <= '0;
		end
		if (cmd.finish) begin
			kind_q <= !found_q ? K_IDLE : (finished ? K_FINISHED : K_RAN);
			idx_q  <= found_q ? pick_q : '0;
			tat_q  <= finished ? (clock_q - rec_q.arrival) : '0;
			rt_q   <= finished ? (rec_q.first_start - rec_q.arrival) : '0;
		end
		if (cmd.emit) begin
			out_q.kind       <= kind_q;
			out_q.job_index  <= IDX_W'(idx_q);
			out_q.time_now   <= OUT_T_W'(start_q);
			out_q.turnaround <= OUT_T_W'(tat_q);
			out_q.waiting    <= OUT_T_W'(wait_w);
			out_q.response   <= OUT_T_W'(rt_q);
			out_q.all_done   <= (fin_count_q == job_count_q);
		end
	end

	assign stat.req_op      = req.operation;
	assign stat.table_empty = (job_count_q == '0);
	assign stat.scan_last   = ((CW'(scan_idx_q) + CW'(1)) == job_count_q);
	assign stat.out_free    = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: joins controller and
// datapath. Depends on pps_pkg, pps_ctrl and pps_dpath.
//
// The block keeps a table of up to MAX_JOBS jobs and takes one request beat
// at a time on the req channel. A load beat (operation 0) enters a job with
// its arrival time, burst and priority into the next free slot, or is
// refused when the burst is zero or the table is full. A tick beat
// (operation 1) advances time by one unit: the table is read one entry per
// cycle through the single read port of the job memory, and the ready,
// unfinished job with the largest priority (lowest index on a tie) runs for
// that unit. A tick therefore lasts longer the more jobs the table holds,
// since the scan goes over the memory port. When a job's last unit runs,
// the result beat carries its turnaround, waiting and response times. The
// clock stops at its largest value. The result sits in an output register,
// so the next request is taken while an earlier result waits on rsp_stall;
// req_stall is high while a request is being worked on.
module preemptive_priority_scheduler #(
	parameter int MAX_JOBS  = pps_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pps_pkg::in_beat_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pps_pkg::out_beat_t rsp
);
	import pps_pkg::*;

	// Commands from the controller and status back from the datapath are the
	// only links between the two halves.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pps_dpath #(
		.MAX_JOBS  (MAX_JOBS),
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

>>> rtl/pps_checker.sv
// Port-level checks for the preemptive priority scheduler, bound to the top
// level. Depends on pps_pkg and preemptive_priority_scheduler.
module pps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input pps_pkg::out_beat_t rsp
);
	import pps_pkg::*;

	// A held result beat must not change.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// One request at a time: the block is busy in the cycle after a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while the previous one is still at work");

	// Timing figures appear only on a finishing beat.
	a_times_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind != K_FINISHED) |->
		(rsp.turnaround == '0) && (rsp.waiting == '0) && (rsp.response == '0))
		else $error("timing figures on a beat that finishes no job");

	// Idle ticks and refused loads name no job.
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.kind == K_IDLE) || (rsp.kind == K_REFUSED)) |->
		(rsp.job_index == '0))
		else $error("job index on an idle or refused beat");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
